>>> hdl/epm_pkg.sv
// Package with the word types, codes, constants and divider/cell control types of the matcher.
package epm_pkg;

  localparam int PIXELS_MAX_DEF  = 4096;
  localparam int EIGEN_MAX_DEF   = 32;
  localparam int SAMPLES_MAX_DEF = 64;

  localparam int QW      = 17;
  localparam int DIV_NW  = 54;
  localparam int DIV_DW  = 48;
  localparam int DIST_W  = 54;
  localparam int WSUM_W  = 38;

  localparam logic [1:0] OP_MEAN  = 2'd0;
  localparam logic [1:0] OP_EIGEN = 2'd1;
  localparam logic [1:0] OP_COEF  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [2:0] REG_IMAGE_LENGTH  = 3'd0;
  localparam logic [2:0] REG_EIGEN_COUNT   = 3'd1;
  localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd2;
  localparam logic [2:0] REG_DISTANCE_GATE = 3'd3;
  localparam logic [2:0] REG_SPREAD_GATE   = 3'd4;

  localparam logic [12:0] IMAGE_LENGTH_RST  = 13'd4096;
  localparam logic [5:0]  EIGEN_COUNT_RST   = 6'd8;
  localparam logic [6:0]  SAMPLE_COUNT_RST  = 7'd64;
  localparam logic [31:0] DISTANCE_GATE_RST = 32'd140000000;
  localparam logic [16:0] SPREAD_GATE_RST   = 17'd29491;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [16:0]        address;
    logic signed [31:0] value;
    logic               final_pixel;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  sample_index;
    logic [16:0] score;
    logic        run_end;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

>>> hdl/epm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/epm_cell.sv
// One projection sum cell of the rotating accumulator chain.
module epm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  epm_pkg::cell_ctl_t ctl,
  input  logic signed [63:0] din,
  output logic signed [63:0] q
);

  logic signed [63:0] value_r;
  logic signed [63:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.clear) begin
      value_nxt = '0;
    end else if (ctl.shift) begin
      value_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign q = value_r;

endmodule

>>> hdl/epm_div.sv
// Restoring divider that produces a 17-bit quotient, one bit per cycle.
module epm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  epm_pkg::div_req_t req,
  output epm_pkg::div_rsp_t rsp
);
  import epm_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [QW-1:0]     num_r, num_nxt;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    trial    = {rem_r, num_r[QW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    cnt_nxt  = cnt_r;
    done_nxt = (cnt_r == CW'(1));
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      cnt_nxt = CW'(QW);
      rem_nxt = DIV_DW'(req.num >> QW);
      num_nxt = req.num[QW-1:0];
      den_nxt = req.den;
      quo_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_nxt = {num_r[QW-2:0], 1'b0};
      quo_nxt = {quo_r[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> hdl/eigenface_projection_matcher_top.sv
// Top level of the eigenface projection matcher: tables, accumulator chain and scoring sequencer.
//
//   channel  ports                          handshake
//   input    start, busy, in_word           taken when start is high and busy is low
//   result   out_valid, out_word            one cycle per word, always taken
//   config   cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A query pixel is centred and then accumulated into the projections by the
// shared multiply-accumulate walking the ring of EIGEN_MAX cells once per pixel.
// A final pixel then adds a distance pass over the samples, a score pass through the
// divider when the best distance is under the gate, and the result words.
// Reset clears control state and the projection cells.
// The receiver cannot stall; busy stays high until the last word has been shown.
module eigenface_projection_matcher_top #(
  parameter int PIXELS_MAX  = epm_pkg::PIXELS_MAX_DEF,
  parameter int EIGEN_MAX   = epm_pkg::EIGEN_MAX_DEF,
  parameter int SAMPLES_MAX = epm_pkg::SAMPLES_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  epm_pkg::in_word_t in_word,
  output logic              out_valid,
  output epm_pkg::out_word_t out_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import epm_pkg::*;

  localparam int JW      = (EIGEN_MAX > 1) ? $clog2(EIGEN_MAX) : 1;
  localparam int SW      = $clog2(SAMPLES_MAX);
  localparam int MEAN_AW = $clog2(PIXELS_MAX);
  localparam int EIG_AW  = $clog2(PIXELS_MAX * EIGEN_MAX);
  localparam int COEF_AW = $clog2(SAMPLES_MAX * EIGEN_MAX);
  localparam logic signed [64:0] ACC_LIM  = 65'sd1 <<< 62;
  localparam logic [46:0]        PROJ_LIM = {47{1'b1}};

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_CENTER = 18'h00002,
    S_MAC    = 18'h00004,
    S_DRAIN  = 18'h00008,
    S_RD     = 18'h00010,
    S_LD     = 18'h00020,
    S_DST    = 18'h00040,
    S_DIV    = 18'h00080,
    S_MUL    = 18'h00100,
    S_ACC    = 18'h00200,
    S_GATE   = 18'h00400,
    S_SCORE  = 18'h00800,
    S_SDIV   = 18'h01000,
    S_SWR    = 18'h02000,
    S_ORD    = 18'h04000,
    S_OLD    = 18'h08000,
    S_ODIV   = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0] image_length_r;
  logic [5:0]  eigen_count_r;
  logic [6:0]  sample_count_r;
  logic [31:0] distance_gate_r;
  logic [16:0] spread_gate_r;

  logic [JW-1:0] j_r, j_nxt;
  logic [SW-1:0] i_r, i_nxt;
  logic          pass_r, pass_nxt;
  logic          zero_r, zero_nxt;
  logic          fin_r, fin_nxt;
  logic          v1_r, v2_r, en1_r, en2_r;

  logic [MEAN_AW-1:0]  addr_r, addr_nxt;
  logic [7:0]          pix_r, pix_nxt;
  logic signed [31:0]  d_r, d_nxt;
  logic signed [63:0]  prod_r;
  logic [31:0]         a_r, a_nxt;
  logic [46:0]         b_r, b_nxt;
  logic                same_r, same_nxt;
  logic [QW-1:0]       r_r, r_nxt;
  logic [48:0]         prod2_r, prod2_nxt;
  logic [DIV_NW-1:0]   acc_r, acc_nxt;
  logic [WSUM_W-1:0]   wsum_r, wsum_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [QW-1:0]       score_r, score_nxt;
  logic [QW-1:0]       smin_r, smin_nxt, smax_r, smax_nxt;

  logic        in_acc;
  logic [16:0] nl;
  logic [6:0]  ne, ns;
  logic        last_j, last_i, en_j;

  logic [31:0] mean_rdata, eig_rdata, coef_rdata;
  logic [QW-1:0] score_rdata;
  logic        mean_we, eig_we, coef_we, score_we;
  logic [EIG_AW-1:0]  eig_raddr;
  logic [COEF_AW-1:0] coef_raddr;

  logic signed [33:0] dwide;
  logic signed [47:0] tval;
  logic signed [64:0] hsum;
  logic signed [63:0] hsat, q_last, din0;
  logic signed [63:0] cell_q [EIGEN_MAX];
  cell_ctl_t          cell_ctl;

  logic [63:0] qmag;
  logic [31:0] cmag;
  logic [46:0] pmag;
  logic [31:0] mn;
  logic [46:0] adiff;
  logic [DIST_W-1:0] dist_sum;
  logic        norm;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign nl = (image_length_r == '0) ? 17'd1 :
              ((32'(image_length_r) > PIXELS_MAX) ? 17'(PIXELS_MAX) : 17'(image_length_r));
  assign ne = (eigen_count_r == '0) ? 7'd1 :
              ((32'(eigen_count_r) > EIGEN_MAX) ? 7'(EIGEN_MAX) : 7'(eigen_count_r));
  assign ns = (sample_count_r < 7'd2) ? 7'd2 :
              ((32'(sample_count_r) > SAMPLES_MAX) ? 7'(SAMPLES_MAX) : sample_count_r);

  assign last_j = (j_r == JW'(EIGEN_MAX - 1));
  assign last_i = (7'(i_r) == ns - 7'd1);
  assign en_j   = (7'(j_r) < ne);

  assign mean_we = in_acc && (in_word.opcode == OP_MEAN) && (32'(in_word.address) < PIXELS_MAX);
  assign eig_we  = in_acc && (in_word.opcode == OP_EIGEN) &&
                   (32'(in_word.address) < PIXELS_MAX * EIGEN_MAX);
  assign coef_we = in_acc && (in_word.opcode == OP_COEF) &&
                   (32'(in_word.address) < SAMPLES_MAX * EIGEN_MAX);
  assign score_we = (state_r == S_SWR);

  assign eig_raddr  = EIG_AW'(32'(addr_r) * 32'(EIGEN_MAX) + 32'(j_r));
  assign coef_raddr = COEF_AW'(32'(i_r) * 32'(EIGEN_MAX) + 32'(j_r));

  epm_ram #(.W(32), .DEPTH(PIXELS_MAX)) u_mean (
    .clk(clk), .we(mean_we), .waddr(MEAN_AW'(in_word.address)), .wdata(in_word.value),
    .raddr(MEAN_AW'(in_word.address)), .rdata(mean_rdata)
  );

  epm_ram #(.W(32), .DEPTH(PIXELS_MAX * EIGEN_MAX)) u_eigen (
    .clk(clk), .we(eig_we), .waddr(EIG_AW'(in_word.address)), .wdata(in_word.value),
    .raddr(eig_raddr), .rdata(eig_rdata)
  );

  epm_ram #(.W(32), .DEPTH(SAMPLES_MAX * EIGEN_MAX)) u_coef (
    .clk(clk), .we(coef_we), .waddr(COEF_AW'(in_word.address)), .wdata(in_word.value),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  epm_ram #(.W(QW), .DEPTH(SAMPLES_MAX)) u_score (
    .clk(clk), .we(score_we), .waddr(i_r), .wdata(score_r),
    .raddr(i_r), .rdata(score_rdata)
  );

  epm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Accumulator chain: the last cell always holds the next component in order.
  assign q_last = cell_q[EIGEN_MAX-1];
  assign tval   = en2_r ? prod_r[63:16] : 48'sd0;
  assign hsum   = {q_last[63], q_last} + {{17{tval[47]}}, tval};
  assign hsat   = (hsum > ACC_LIM) ? 64'(ACC_LIM) :
                  ((hsum < -ACC_LIM) ? 64'(-ACC_LIM) : hsum[63:0]);
  assign din0   = (state_r == S_LD) ? q_last : hsat;
  assign cell_ctl.shift = (state_r == S_LD) || v2_r;
  assign cell_ctl.clear = (state_r == S_OUT) && last_i;

  for (genvar k = 0; k < EIGEN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      epm_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(cell_ctl), .din(din0), .q(cell_q[k]));
    end else begin : g_body
      epm_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(cell_ctl), .din(cell_q[k-1]),
                       .q(cell_q[k]));
    end
  end

  always_comb begin
    dwide = $signed({10'b0, pix_r, 16'b0}) - {{2{mean_rdata[31]}}, mean_rdata};
    qmag  = q_last[63] ? 64'(-q_last) : q_last;
    pmag  = (qmag > 64'(PROJ_LIM)) ? PROJ_LIM : qmag[46:0];
    cmag  = coef_rdata[31] ? (32'd0 - coef_rdata) : coef_rdata;
    mn    = ({15'b0, a_r} < b_r) ? a_r : b_r[31:0];
    adiff = ({15'b0, a_r} > b_r) ? ({15'b0, a_r} - b_r) : (b_r - {15'b0, a_r});
    dist_sum = dist_r + DIST_W'(adiff);
    norm  = (smax_r > spread_gate_r);
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.den   = DIV_DW'({16'b0, a_r} + {1'b0, b_r});
    div_req.num   = DIV_NW'({mn, 17'b0});
    unique case (state_r)
      S_DST: begin
        div_req.start = same_r;
      end
      S_SCORE: begin
        div_req.start = (wsum_r != '0);
        div_req.num   = acc_r;
        div_req.den   = DIV_DW'(wsum_r);
      end
      S_OLD: begin
        div_req.start = !zero_r && norm && (smax_r > smin_r);
        div_req.num   = DIV_NW'({score_rdata - smin_r, 16'b0});
        div_req.den   = DIV_DW'(smax_r - smin_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    pass_nxt  = pass_r;
    zero_nxt  = zero_r;
    fin_nxt   = fin_r;
    addr_nxt  = addr_r;
    pix_nxt   = pix_r;
    d_nxt     = d_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    same_nxt  = same_r;
    r_nxt     = r_r;
    prod2_nxt = prod2_r;
    acc_nxt   = acc_r;
    wsum_nxt  = wsum_r;
    dist_nxt  = dist_r;
    best_nxt  = best_r;
    score_nxt = score_r;
    smin_nxt  = smin_r;
    smax_nxt  = smax_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_word.opcode == OP_QUERY)) begin
          addr_nxt = MEAN_AW'(in_word.address);
          fin_nxt  = in_word.final_pixel;
          pix_nxt  = in_word.value[31] ? 8'd0 :
                     ((in_word.value > 32'sd255) ? 8'd255 : in_word.value[7:0]);
          if (in_word.address < nl) begin
            state_nxt = S_CENTER;
          end else if (in_word.final_pixel) begin
            i_nxt     = '0;
            j_nxt     = '0;
            pass_nxt  = 1'b0;
            dist_nxt  = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_CENTER: begin
        if (dwide[33:31] == 3'b000 || dwide[33:31] == 3'b111) begin
          d_nxt = dwide[31:0];
        end else begin
          d_nxt = dwide[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        j_nxt     = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        j_nxt = j_r + JW'(1);
        if (last_j) begin
          j_nxt     = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          if (fin_r) begin
            i_nxt     = '0;
            j_nxt     = '0;
            pass_nxt  = 1'b0;
            dist_nxt  = '0;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        a_nxt    = en_j ? cmag : 32'd0;
        b_nxt    = en_j ? pmag : 47'd0;
        same_nxt = en_j && ((!coef_rdata[31] && coef_rdata != '0 && !q_last[63] &&
                              q_last != '0) || (coef_rdata[31] && q_last[63]));
        state_nxt = pass_r ? S_DST : S_ACC;
      end
      S_DST: begin
        if (same_r) begin
          state_nxt = S_DIV;
        end else begin
          r_nxt     = '0;
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          r_nxt     = div_rsp.quo;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod2_nxt = a_r * r_r;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!pass_r) begin
          if (last_j) begin
            j_nxt    = '0;
            dist_nxt = '0;
            if (i_r == '0 || dist_sum < best_r) begin
              best_nxt = dist_sum;
            end
            if (last_i) begin
              state_nxt = S_GATE;
            end else begin
              i_nxt     = i_r + SW'(1);
              state_nxt = S_RD;
            end
          end else begin
            dist_nxt  = dist_sum;
            j_nxt     = j_r + JW'(1);
            state_nxt = S_RD;
          end
        end else begin
          acc_nxt  = acc_r + DIV_NW'(prod2_r);
          wsum_nxt = wsum_r + WSUM_W'(a_r);
          if (last_j) begin
            j_nxt     = '0;
            state_nxt = S_SCORE;
          end else begin
            j_nxt     = j_r + JW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_GATE: begin
        zero_nxt  = !(best_r < DIST_W'({distance_gate_r, 16'b0}));
        i_nxt     = '0;
        j_nxt     = '0;
        pass_nxt  = 1'b1;
        acc_nxt   = '0;
        wsum_nxt  = '0;
        state_nxt = (best_r < DIST_W'({distance_gate_r, 16'b0})) ? S_RD : S_ORD;
      end
      S_SCORE: begin
        if (wsum_r != '0) begin
          state_nxt = S_SDIV;
        end else begin
          score_nxt = '0;
          state_nxt = S_SWR;
        end
      end
      S_SDIV: begin
        if (div_rsp.done) begin
          score_nxt = div_rsp.quo;
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        if (i_r == '0 || score_r < smin_r) begin
          smin_nxt = score_r;
        end
        if (i_r == '0 || score_r > smax_r) begin
          smax_nxt = score_r;
        end
        acc_nxt  = '0;
        wsum_nxt = '0;
        if (last_i) begin
          i_nxt     = '0;
          state_nxt = S_ORD;
        end else begin
          i_nxt     = i_r + SW'(1);
          state_nxt = S_RD;
        end
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        state_nxt = S_OUT;
        if (zero_r) begin
          score_nxt = '0;
        end else if (norm) begin
          if (smax_r > smin_r) begin
            state_nxt = S_ODIV;
          end else begin
            score_nxt = '0;
          end
        end else begin
          score_nxt = score_rdata;
        end
      end
      S_ODIV: begin
        if (div_rsp.done) begin
          score_nxt = div_rsp.quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (last_i) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + SW'(1);
          state_nxt = S_ORD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      j_r             <= '0;
      i_r             <= '0;
      pass_r          <= 1'b0;
      zero_r          <= 1'b0;
      fin_r           <= 1'b0;
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      en1_r           <= 1'b0;
      en2_r           <= 1'b0;
      image_length_r  <= IMAGE_LENGTH_RST;
      eigen_count_r   <= EIGEN_COUNT_RST;
      sample_count_r  <= SAMPLE_COUNT_RST;
      distance_gate_r <= DISTANCE_GATE_RST;
      spread_gate_r   <= SPREAD_GATE_RST;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      pass_r  <= pass_nxt;
      zero_r  <= zero_nxt;
      fin_r   <= fin_nxt;
      v1_r    <= (state_r == S_MAC);
      v2_r    <= v1_r;
      en1_r   <= (state_r == S_MAC) && en_j;
      en2_r   <= en1_r;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_LENGTH:  image_length_r  <= cfg_data[12:0];
          REG_EIGEN_COUNT:   eigen_count_r   <= cfg_data[5:0];
          REG_SAMPLE_COUNT:  sample_count_r  <= cfg_data[6:0];
          REG_DISTANCE_GATE: distance_gate_r <= cfg_data;
          REG_SPREAD_GATE:   spread_gate_r   <= cfg_data[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    pix_r   <= pix_nxt;
    d_r     <= d_nxt;
    prod_r  <= d_r * $signed(eig_rdata);
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    same_r  <= same_nxt;
    r_r     <= r_nxt;
    prod2_r <= prod2_nxt;
    acc_r   <= acc_nxt;
    wsum_r  <= wsum_nxt;
    dist_r  <= dist_nxt;
    best_r  <= best_nxt;
    score_r <= score_nxt;
    smin_r  <= smin_nxt;
    smax_r  <= smax_nxt;
  end

  assign out_valid             = (state_r == S_OUT);
  assign out_word.sample_index = 6'(i_r);
  assign out_word.score        = score_r;
  assign out_word.run_end      = last_i;

endmodule

>>> hdl/epm_checker.sv
// Port-level checker for the matcher top level and its bind statement.
module epm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input epm_pkg::in_word_t  in_word,
  input logic               out_valid,
  input epm_pkg::out_word_t out_word
);
  import epm_pkg::*;

  a_out_busy: assert property (@(posedge clk) out_valid |-> busy)
    else $error("result word shown while not busy");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.run_end |=> !out_valid && !busy)
    else $error("block still busy after the last result word");

  a_word_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.run_end |=> !out_valid && busy)
    else $error("result words not separated inside a run");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.opcode != OP_QUERY |=> !busy)
    else $error("table load left the block busy");

endmodule

bind eigenface_projection_matcher_top epm_checker u_epm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
  .out_valid(out_valid), .out_word(out_word)
);
